// ----- rtl/lpcd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcd_pkg: shared types and constants of the command deframer
// Frame geometry, status codes, register map and the job passed from the
// parser to the result sequencer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  // Frame store geometry
  localparam int MAX_FRAME_BYTES = 64;
  localparam int HDR_BYTES       = 4;
  localparam int OVERHEAD_BYTES  = 5;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int CNT_W           = ADDR_W + 1;
  localparam int LEN_W           = ADDR_W;

  // Field widths of the channels
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int DLEN_W   = 6;

  // Queue between parser and sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_SYNC     = 2'd0;
  localparam logic [1:0] REG_FLAG     = 2'd1;
  localparam logic [1:0] REG_MAX_COPY = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'hAA;
  localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'hBB;
  localparam logic [DLEN_W-1:0] MAX_COPY_RESET = 6'd58;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA = 3'd0,
    ST_CSUM = 3'd1,
    ST_LEN  = 3'd2,
    ST_FLAG = 3'd3,
    ST_LONG = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   cmd;
    logic [DLEN_W-1:0]   dlen;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

endpackage

// ----- rtl/lpcd_if.sv -----
// ----------------------------------------------------------------------------
// lpcd_if: request channels of the command deframer
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpcd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lpcd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpcd_pkg::STATUS_W-1:0] status;
  logic [lpcd_pkg::BYTE_W-1:0]   cmd_code;
  logic [lpcd_pkg::BYTE_W-1:0]   data_byte;
  logic                          data_valid;
  logic [lpcd_pkg::DLEN_W-1:0]   data_len;
  logic                          last;

  modport source (output valid, output status, output cmd_code, output data_byte,
                  output data_valid, output data_len, output last, input ready);
  modport sink   (input valid, input status, input cmd_code, input data_byte,
                  input data_valid, input data_len, input last, output ready);
endinterface

// ----- rtl/lpcd_ram.sv -----
// ----------------------------------------------------------------------------
// lpcd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lpcd_front.sv -----
// ----------------------------------------------------------------------------
// lpcd_front: frame parser
// Hunts for the sync byte, checks flag, length and checksum, stores the
// frame bytes and posts one job per outcome to the queue.
// ----------------------------------------------------------------------------
module lpcd_front (
  input  logic                          clk,
  input  logic                          rst,
  lpcd_in_if.sink                       rx,
  input  logic [lpcd_pkg::BYTE_W-1:0]   sync_byte,
  input  logic [lpcd_pkg::BYTE_W-1:0]   flag_byte,
  input  logic [lpcd_pkg::DLEN_W-1:0]   max_copy_len,
  input  logic                          q_full,
  input  logic                          drain_done,
  output logic                          push,
  output lpcd_pkg::job_t                push_job,
  output lpcd_pkg::ram_wr_t             wr
);

  localparam int CW = lpcd_pkg::CNT_W;
  localparam int LW = lpcd_pkg::LEN_W;
  localparam int DW = lpcd_pkg::DLEN_W;

  logic                        in_frame, in_frame_next;
  logic [CW-1:0]               count, count_next;
  logic [7:0]                  sum, sum_next;
  logic [7:0]                  len_hi, len_hi_next;
  logic [LW-1:0]               len, len_next;
  logic [7:0]                  cmd, cmd_next;
  logic                        busy, busy_next;
  logic                        accept;
  logic [7:0]                  b;
  logic [15:0]                 len16;
  logic                        len_bad;
  logic [DW-1:0]               dlen;

  // Input is held off while a good frame is still being read out of the store.
  assign rx.ready = !q_full && !busy;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign len16    = {len_hi, b};
  assign len_bad  = (len16 == 16'd0) ||
                    (len16 > 16'(lpcd_pkg::MAX_FRAME_BYTES - lpcd_pkg::OVERHEAD_BYTES));
  assign dlen     = DW'(len - LW'(1));

  always_comb begin
    in_frame_next = in_frame;
    count_next    = count;
    sum_next      = sum;
    len_hi_next   = len_hi;
    len_next      = len;
    cmd_next      = cmd;
    busy_next     = busy;
    push          = 1'b0;
    push_job      = '0;
    wr            = '0;
    if (drain_done) begin
      busy_next = 1'b0;
    end
    if (accept) begin
      if (!in_frame) begin
        if (b == sync_byte) begin
          wr            = '{we: 1'b1, addr: '0, data: b};
          count_next    = CW'(1);
          sum_next      = b;
          in_frame_next = 1'b1;
        end
      end else if (count >= CW'(lpcd_pkg::MAX_FRAME_BYTES)) begin
        in_frame_next   = 1'b0;
        count_next      = '0;
        push            = 1'b1;
        push_job.status = lpcd_pkg::ST_LONG;
        if (b == sync_byte) begin
          wr            = '{we: 1'b1, addr: '0, data: b};
          count_next    = CW'(1);
          sum_next      = b;
          in_frame_next = 1'b1;
        end
      end else if (count == CW'(lpcd_pkg::HDR_BYTES - 1) && b != flag_byte) begin
        in_frame_next   = 1'b0;
        count_next      = '0;
        push            = 1'b1;
        push_job.status = lpcd_pkg::ST_FLAG;
      end else if (count == CW'(2) && len_bad) begin
        in_frame_next   = 1'b0;
        count_next      = '0;
        push            = 1'b1;
        push_job.status = lpcd_pkg::ST_LEN;
      end else if (count >= CW'(lpcd_pkg::HDR_BYTES) &&
                   count == CW'(len) + CW'(lpcd_pkg::HDR_BYTES)) begin
        // This byte is the checksum of the frame.
        in_frame_next = 1'b0;
        count_next    = '0;
        push          = 1'b1;
        push_job.cmd  = cmd;
        push_job.dlen = dlen;
        if (sum != b) begin
          push_job.status = lpcd_pkg::ST_CSUM;
        end else if (dlen > max_copy_len) begin
          push_job.status = lpcd_pkg::ST_LONG;
        end else begin
          push_job.status = lpcd_pkg::ST_DATA;
          if (dlen != '0) begin
            busy_next = 1'b1;
          end
        end
      end else begin
        wr         = '{we: 1'b1, addr: count[lpcd_pkg::ADDR_W-1:0], data: b};
        count_next = count + CW'(1);
        sum_next   = sum + b;
        if (count == CW'(1)) begin
          len_hi_next = b;
        end
        if (count == CW'(2)) begin
          len_next = LW'(len16);
        end
        if (count == CW'(lpcd_pkg::HDR_BYTES)) begin
          cmd_next = b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      count    <= '0;
      sum      <= '0;
      len_hi   <= '0;
      len      <= '0;
      cmd      <= '0;
      busy     <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
      count    <= count_next;
      sum      <= sum_next;
      len_hi   <= len_hi_next;
      len      <= len_next;
      cmd      <= cmd_next;
      busy     <= busy_next;
    end
  end

endmodule

// ----- rtl/lpcd_queue.sv -----
// ----------------------------------------------------------------------------
// lpcd_queue: job queue between parser and sequencer
// A short first-in first-out store of parser outcomes.
// ----------------------------------------------------------------------------
module lpcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpcd_pkg::job_t push_job,
  input  logic           pop,
  output lpcd_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);

  localparam int PW = lpcd_pkg::QPTR_W;

  lpcd_pkg::job_t  entries [lpcd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [PW:0]     fill;

  assign full    = (fill == (PW + 1)'(lpcd_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr          <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW + 1)'(1);
      end
    end
  end

endmodule

// ----- rtl/lpcd_back.sv -----
// ----------------------------------------------------------------------------
// lpcd_back: result sequencer
// Takes jobs from the queue, turns status jobs into single results and reads
// a good frame's data bytes out of the store one by one.
// ----------------------------------------------------------------------------
module lpcd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  lpcd_pkg::job_t               job,
  output logic                         pop,
  output logic                         re,
  output logic [lpcd_pkg::ADDR_W-1:0]  raddr,
  input  logic [lpcd_pkg::BYTE_W-1:0]  rdata,
  output logic                         drain_done,
  lpcd_out_if.source                   res
);

  localparam int DW = lpcd_pkg::DLEN_W;
  localparam int AW = lpcd_pkg::ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  state_t         state;
  logic [7:0]     cmd;
  logic [DW-1:0]  dlen;
  logic [DW-1:0]  idx;
  logic [DW-1:0]  idx_inc;
  logic           is_last;
  logic           out_free;
  logic           out_load;

  logic                         out_valid;
  logic [lpcd_pkg::STATUS_W-1:0] out_status;
  logic [7:0]                   out_cmd;
  logic [7:0]                   out_data;
  logic                         out_dv;
  logic [DW-1:0]                out_dlen;
  logic                         out_last;

  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.cmd_code   = out_cmd;
  assign res.data_byte  = out_data;
  assign res.data_valid = out_dv;
  assign res.data_len   = out_dlen;
  assign res.last       = out_last;

  assign out_free   = !out_valid || res.ready;
  assign pop        = (state == S_IDLE) && !q_empty && out_free;
  // A read is only issued when the output register will be free by the time
  // the data comes back.
  assign re         = (state == S_READ) && out_free;
  assign raddr      = AW'(lpcd_pkg::HDR_BYTES + 1) + AW'(idx);
  assign idx_inc    = idx + DW'(1);
  assign is_last    = (idx_inc == dlen);
  assign drain_done = (state == S_LOAD) && is_last;
  assign out_load   = (state == S_LOAD) ||
                      (pop && !(job.status == lpcd_pkg::ST_DATA && job.dlen != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (job.status == lpcd_pkg::ST_DATA && job.dlen != '0) begin
              cmd   <= job.cmd;
              dlen  <= job.dlen;
              idx   <= '0;
              state <= S_READ;
            end else begin
              out_status <= job.status;
              out_cmd    <= job.cmd;
              out_data   <= '0;
              out_dv     <= 1'b0;
              out_dlen   <= job.dlen;
              out_last   <= 1'b1;
            end
          end
        end
        S_READ: begin
          if (re) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          out_status <= lpcd_pkg::ST_DATA;
          out_cmd    <= cmd;
          out_data   <= rdata;
          out_dv     <= 1'b1;
          out_dlen   <= dlen;
          out_last   <= is_last;
          if (is_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/length_prefixed_command_deframer_top.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_command_deframer_top: command frame receiver
// Parses sync, length, flag, payload and checksum and emits command results.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the parser hunts for a sync byte
// and collects a frame, as long as the job queue is not full and no good frame
// is being read out. Each frame outcome goes through a two-entry job queue to
// the result sequencer, so status results (flag wrong, bad length, bad checksum,
// data too long, empty data) cost the input nothing while the queue has room. A
// good frame holds the input off after its checksum byte until the sequencer
// has read its data bytes out of the frame store through its single registered
// read port, one read and one output load per data byte; a stalled result
// output stretches this further. The frame store needs no clearing pass after
// reset, and configuration should be written only while the block is idle.
module length_prefixed_command_deframer_top (
  input  logic                           clk,
  input  logic                           rst,
  lpcd_in_if.sink                        rx,
  lpcd_out_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpcd_pkg::PADDR_W-1:0]   paddr,
  input  logic [lpcd_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpcd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int PW = lpcd_pkg::PDATA_W;

  logic [7:0]                  sync_byte;
  logic [7:0]                  flag_byte;
  logic [lpcd_pkg::DLEN_W-1:0] max_copy_len;
  logic [1:0]                  reg_idx;

  logic                        push;
  lpcd_pkg::job_t              push_job;
  logic                        pop;
  lpcd_pkg::job_t              pop_job;
  logic                        q_full;
  logic                        q_empty;
  logic                        drain_done;
  lpcd_pkg::ram_wr_t           wr;
  logic                        re;
  logic [lpcd_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                  rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lpcd_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte    <= lpcd_pkg::SYNC_RESET;
      flag_byte    <= lpcd_pkg::FLAG_RESET;
      max_copy_len <= lpcd_pkg::MAX_COPY_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        lpcd_pkg::REG_SYNC:     sync_byte    <= pwdata[7:0];
        lpcd_pkg::REG_FLAG:     flag_byte    <= pwdata[7:0];
        lpcd_pkg::REG_MAX_COPY: max_copy_len <= pwdata[lpcd_pkg::DLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lpcd_pkg::REG_SYNC:     prdata = PW'(sync_byte);
      lpcd_pkg::REG_FLAG:     prdata = PW'(flag_byte);
      lpcd_pkg::REG_MAX_COPY: prdata = PW'(max_copy_len);
      default:                prdata = '0;
    endcase
  end

  lpcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .sync_byte    (sync_byte),
    .flag_byte    (flag_byte),
    .max_copy_len (max_copy_len),
    .q_full       (q_full),
    .drain_done   (drain_done),
    .push         (push),
    .push_job     (push_job),
    .wr           (wr)
  );

  lpcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  lpcd_ram #(
    .WIDTH (lpcd_pkg::BYTE_W),
    .DEPTH (lpcd_pkg::MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .job        (pop_job),
    .pop        (pop),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .drain_done (drain_done),
    .res        (res)
  );

endmodule
